### hw/rtl/leh_pkg.sv
// ----------------------------------------------------------------------------
// leh_pkg
// Shared widths, defaults and the saturating add for the layer energy sums.
// ----------------------------------------------------------------------------
package leh_pkg;

  localparam int LAYER_W        = 6;
  localparam int ADC_W          = 16;
  localparam int SUM_W          = 24;
  localparam int NUM_LAYERS_DEF = 50;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_EOE = 1'b1;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] acc,
                                               input logic [ADC_W-1:0] val);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + (SUM_W + 1)'(val);
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

### hw/rtl/layer_energy_histogram_sum.sv
// ----------------------------------------------------------------------------
// layer_energy_histogram_sum
// Per-event energy sums by detector layer plus an event total, read out
// in layer order at end of event and cleared during the readout.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------
//  command  | start, busy             | action_i, layer_number_i, adc_value_i
//  result   | result_valid_o (strobe) | is_total_o, layer_index_o,
//           |                         | energy_sum_o, last_o
//
//  an add item is taken every cycle while not busy; its layer sum is read from the ram,
//  updated and written back in the following cycle, with forwarding between
//  back-to-back adds to the same layer.
//  end of event holds busy through the readout: one ram read per layer,
//  then the total in the cycle after the last layer sum.
//  after reset all sums read as zero through per-layer valid flags, no
//  clearing pass; the receiver cannot stall, results go out one per cycle.
// ----------------------------------------------------------------------------
module layer_energy_histogram_sum #(
  parameter int NUM_LAYERS = leh_pkg::NUM_LAYERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic [leh_pkg::LAYER_W-1:0]  layer_number_i,
  input  logic [leh_pkg::ADC_W-1:0]    adc_value_i,
  output logic                         result_valid_o,
  output logic                         is_total_o,
  output logic [leh_pkg::LAYER_W-1:0]  layer_index_o,
  output logic [leh_pkg::SUM_W-1:0]    energy_sum_o,
  output logic                         last_o
);

  import leh_pkg::*;

  localparam int IDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_TOTAL
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             lay_pend_q, lay_pend_d;
  logic [IDX_W-1:0] lay_idx_q, lay_idx_d;

  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [ADC_W-1:0] s1_adc_q;
  logic             fwd_q;
  logic [SUM_W-1:0] fwd_data_q;
  logic [SUM_W-1:0] total_q;
  logic             vld_q [NUM_LAYERS];

  logic             accept;
  logic             add_acc;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;
  logic [SUM_W-1:0] rdata;
  logic [SUM_W-1:0] old_sum;
  logic [SUM_W-1:0] new_sum;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (layer_number_i < LAYER_W'(NUM_LAYERS));
  assign in_idx   = layer_number_i[IDX_W-1:0];
  assign add_acc  = accept && (action_i == ACT_ADD) && in_range;

  assign ram_re    = add_acc || (state_q == ST_READ);
  assign ram_raddr = (state_q == ST_READ) ? rd_idx_q : in_idx;

  assign old_sum = fwd_q ? fwd_data_q : (vld_q[s1_idx_q] ? rdata : '0);
  assign new_sum = sat_add(old_sum, s1_adc_q);

  leh_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_LAYERS),
    .AW    (IDX_W)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_idx_q),
    .wdata_i (new_sum),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    lay_pend_d = 1'b0;
    lay_idx_d  = lay_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (action_i == ACT_EOE)) begin
          state_d  = ST_READ;
          rd_idx_d = '0;
        end
      end
      ST_READ: begin
        lay_pend_d = 1'b1;
        lay_idx_d  = rd_idx_q;
        if (rd_idx_q == IDX_W'(NUM_LAYERS - 1)) begin
          state_d = ST_LAST;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_idx_q   <= '0;
      lay_pend_q <= 1'b0;
      s1_vld_q   <= 1'b0;
      fwd_q      <= 1'b0;
      total_q    <= '0;
      for (int i = 0; i < NUM_LAYERS; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      state_q    <= state_d;
      rd_idx_q   <= rd_idx_d;
      lay_pend_q <= lay_pend_d;
      s1_vld_q   <= add_acc;
      fwd_q      <= add_acc && s1_vld_q && (in_idx == s1_idx_q);
      if (s1_vld_q) begin
        vld_q[s1_idx_q] <= 1'b1;
      end
      if (accept && (action_i == ACT_ADD)) begin
        total_q <= sat_add(total_q, adc_value_i);
      end
      if (state_q == ST_TOTAL) begin
        total_q <= '0;
        for (int i = 0; i < NUM_LAYERS; i++) begin
          vld_q[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lay_idx_q  <= lay_idx_d;
    fwd_data_q <= new_sum;
    if (add_acc) begin
      s1_idx_q <= in_idx;
      s1_adc_q <= adc_value_i;
    end
  end

  assign result_valid_o = lay_pend_q || (state_q == ST_TOTAL);
  assign is_total_o     = (state_q == ST_TOTAL);
  assign last_o         = (state_q == ST_TOTAL);
  assign layer_index_o  = (state_q == ST_TOTAL) ? '0 : LAYER_W'(lay_idx_q);
  assign energy_sum_o   = (state_q == ST_TOTAL) ? total_q
                        : (vld_q[lay_idx_q] ? rdata : '0);

endmodule

### hw/rtl/leh_ram.sv
// ----------------------------------------------------------------------------
// leh_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module leh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 50,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for layer_energy_histogram_sum. Add and end-of-event
// items go in with random sender gaps in several phases. A scoreboard keeps
// its own per-layer sums and event total, predicts every readout at the end
// of an event, and compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import leh_pkg::*;

  localparam int NUM_LAYERS     = NUM_LAYERS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = NUM_LAYERS + 8;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASE_ITEMS    = 30;
  localparam int SAT_ADDS       = 260;

  typedef struct packed {
    logic               is_total;
    logic [LAYER_W-1:0] layer;
    logic [SUM_W-1:0]   sum;
    logic               last;
  } energy_result_t;

  class energy_scoreboard;
    logic [SUM_W-1:0] layer_acc [NUM_LAYERS];
    logic [SUM_W-1:0] total_acc;
    energy_result_t   readout_q [$];
    int               errors;
    int               reported;

    function new();
      clear_sums();
      errors   = 0;
      reported = 0;
    endfunction

    function void clear_sums();
      foreach (layer_acc[i]) layer_acc[i] = '0;
      total_acc = '0;
    endfunction

    function logic [SUM_W-1:0] add_clamped(logic [SUM_W-1:0] acc, logic [ADC_W-1:0] val);
      logic [SUM_W:0] wide;
      wide = {1'b0, acc} + {{(SUM_W + 1 - ADC_W){1'b0}}, val};
      if (wide > {1'b0, SUM_MAX}) return SUM_MAX;
      return wide[SUM_W-1:0];
    endfunction

    function void fail_note(string msg);
      errors++;
      if (reported < MAX_REPORTS) begin
        reported++;
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endfunction

    function void note_input(logic act, logic [LAYER_W-1:0] layer, logic [ADC_W-1:0] adc);
      energy_result_t r;
      if (act == ACT_ADD) begin
        total_acc = add_clamped(total_acc, adc);
        if (layer < NUM_LAYERS) layer_acc[layer] = add_clamped(layer_acc[layer], adc);
      end else begin
        for (int i = 0; i < NUM_LAYERS; i++) begin
          r.is_total = 1'b0;
          r.layer    = LAYER_W'(i);
          r.sum      = layer_acc[i];
          r.last     = 1'b0;
          readout_q.insert(readout_q.size(), r);
        end
        r.is_total = 1'b1;
        r.layer    = '0;
        r.sum      = total_acc;
        r.last     = 1'b1;
        readout_q.insert(readout_q.size(), r);
        clear_sums();
      end
    endfunction

    function void check(logic is_total, logic [LAYER_W-1:0] layer, logic [SUM_W-1:0] sum,
                        logic last);
      energy_result_t want;
      if (readout_q.size() == 0) begin
        fail_note($sformatf("unexpected result total=%0b layer=%0d sum=%0d last=%0b",
                            is_total, layer, sum, last));
        return;
      end
      want = readout_q.pop_front();
      if (is_total !== want.is_total || layer !== want.layer || sum !== want.sum ||
          last !== want.last) begin
        fail_note($sformatf("expected total=%0b layer=%0d sum=%0d last=%0b, got %0b %0d %0d %0b",
                            want.is_total, want.layer, want.sum, want.last,
                            is_total, layer, sum, last));
      end
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               action_i       = ACT_ADD;
  logic [LAYER_W-1:0] layer_number_i = '0;
  logic [ADC_W-1:0]   adc_value_i    = '0;
  logic               busy;
  logic               result_valid_o;
  logic               is_total_o;
  logic [LAYER_W-1:0] layer_index_o;
  logic [SUM_W-1:0]   energy_sum_o;
  logic               last_o;

  energy_scoreboard sb = new();
  int idle_pct    = 0;
  int items_sent  = 0;
  int quiet_count = 0;

  layer_energy_histogram_sum #(
    .NUM_LAYERS(NUM_LAYERS)
  ) dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .action_i,
    .layer_number_i,
    .adc_value_i,
    .result_valid_o,
    .is_total_o,
    .layer_index_o,
    .energy_sum_o,
    .last_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check(is_total_o, layer_index_o, energy_sum_o, last_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) quiet_count <= 0;
    else quiet_count <= quiet_count + 1;
    if (quiet_count >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [LAYER_W-1:0] layer, logic [ADC_W-1:0] adc);
    start          <= 1'b1;
    action_i       <= act;
    layer_number_i <= layer;
    adc_value_i    <= adc;
    do @(posedge clk_i); while (busy);
    sb.note_input(act, layer, adc);
    items_sent++;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      action_i       <= 1'($urandom);
      layer_number_i <= LAYER_W'($urandom);
      adc_value_i    <= ADC_W'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // hold the sender off until the whole readout has come back
  task automatic drain_readout();
    if (sb.readout_q.size() != 0) begin
      start <= 1'b0;
      while (sb.readout_q.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic random_event(int n_adds);
    logic [LAYER_W-1:0] layer;
    logic [ADC_W-1:0]   adc;
    layer = LAYER_W'($urandom_range(NUM_LAYERS - 1));
    repeat (n_adds) begin
      case ($urandom_range(9))
        0:       layer = LAYER_W'($urandom_range(63));
        1, 2:    ;
        default: layer = LAYER_W'($urandom_range(NUM_LAYERS - 1));
      endcase
      case ($urandom_range(7))
        0:       adc = '1;
        1:       adc = '0;
        default: adc = ADC_W'($urandom);
      endcase
      send_item(ACT_ADD, layer, adc);
    end
    send_item(ACT_EOE, LAYER_W'($urandom), ADC_W'($urandom));
  endtask

  initial begin
    logic [LAYER_W-1:0] sat_layer;
    int                 phase_end;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty event straight after reset, fields of the item ignored
    send_item(ACT_EOE, 6'd63, 16'hFFFF);
    drain_readout();

    send_item(ACT_ADD, 6'd0, 16'hFFFF);
    send_item(ACT_ADD, 6'd0, 16'h0001);
    send_item(ACT_ADD, 6'd0, 16'hFFFF);
    send_item(ACT_ADD, LAYER_W'(NUM_LAYERS - 1), 16'h0000);
    send_item(ACT_ADD, LAYER_W'(NUM_LAYERS - 1), 16'h8000);
    send_item(ACT_ADD, LAYER_W'(NUM_LAYERS), 16'h1234);
    send_item(ACT_ADD, 6'd63, 16'hFFFF);
    send_item(ACT_ADD, 6'd42, 16'h5555);
    send_item(ACT_ADD, 6'd21, 16'hAAAA);
    send_item(ACT_ADD, 6'd1, 16'h7FFF);
    send_item(ACT_EOE, 6'd0, 16'h0000);
    send_item(ACT_EOE, 6'd21, 16'hAAAA);
    send_item(ACT_ADD, LAYER_W'(NUM_LAYERS - 1), 16'hFFFF);
    send_item(ACT_EOE, 6'd42, 16'h5555);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 67;
        3:       idle_pct = 33;
        default: idle_pct = 0;
      endcase
      if (ph == 2) begin
        // drive one layer and the total into saturation and keep adding
        sat_layer = LAYER_W'($urandom_range(NUM_LAYERS - 1));
        repeat (SAT_ADDS) send_item(ACT_ADD, sat_layer, '1);
        send_item(ACT_ADD, LAYER_W'($urandom_range(NUM_LAYERS - 1)), ADC_W'($urandom));
        send_item(ACT_EOE, LAYER_W'($urandom), ADC_W'($urandom));
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_event($urandom_range(0, 14));
    end

    start <= 1'b0;
    @(posedge clk_i);
    drain_readout();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.readout_q.size() != 0)
      sb.fail_note($sformatf("%0d results never arrived", sb.readout_q.size()));
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
